// ----- hdl/rdwo_pkg.sv -----
package rdwo_pkg;

  // Ring geometry.
  localparam int DEPTH = 16;
  localparam int WIDTH = 32;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W = $clog2(DEPTH + 1);

  // Fixed widths of the transaction fields.
  localparam int OP_W   = 3;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_TAIL_WR  = 3'd0,
    OP_TAIL_OVR = 3'd1,
    OP_HEAD_INS = 3'd2,
    OP_HEAD_RD  = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_STATUS   = 3'd5
  } op_t;

endpackage

// ----- hdl/rdwo_ram.sv -----
module rdwo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/ring_deque_with_overwrite_top.sv -----
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall    op, wr_data
// out      source     out_valid / out_stall  accepted, rd_data, fill_count, free_count,
//                                            is_empty, is_full
// cfg      sink       cfg_valid / cfg_ready  capacity
//
// One operation is taken per cycle while the input is not stalled. Its result is
// registered: the registered read port of the entry memory captures the head entry
// at the accepting edge, alongside the pending stage, and the output register then
// loads from them once it is free. Reset (rst, synchronous) empties the ring and sets the
// capacity to DEPTH; no clearing pass is needed because entries are read only after
// they were written. A stalled output holds the result register, the pending stage
// then fills, and the input is stalled until the output drains.
module ring_deque_with_overwrite_top (
  input  logic                        clk,
  input  logic                        rst,
  // Operation channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rdwo_pkg::OP_W-1:0]   op,
  input  logic [rdwo_pkg::DATA_W-1:0] wr_data,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        accepted,
  output logic [rdwo_pkg::DATA_W-1:0] rd_data,
  output logic [rdwo_pkg::CNT_W-1:0]  fill_count,
  output logic [rdwo_pkg::CNT_W-1:0]  free_count,
  output logic                        is_empty,
  output logic                        is_full,
  // Capacity register write channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rdwo_pkg::CNT_W-1:0]  capacity
);

  import rdwo_pkg::*;

  // Status computed at accept time, waiting for the memory read data.
  typedef struct packed {
    logic             accepted;
    logic             is_read;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] free;
    logic             empty;
    logic             full;
  } pend_t;

  // Ring state. The pointers always stay below the capacity in use.
  logic [PTR_W-1:0] wp, wp_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic             full, full_next;
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] cap_sat;

  logic             pend_valid;
  pend_t            pend, pend_next;

  logic             in_acc, cfg_acc, out_load;

  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr;
  logic [WIDTH-1:0] ram_q;

  logic             cur_empty, nxt_empty;
  logic [CAP_W-1:0] fill_v, free_v;
  logic [PTR_W-1:0] wp_inc, rp_inc, rp_dec;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                              input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] n;
    n = CAP_W'(p) + CAP_W'(1);
    return (n == c) ? '0 : PTR_W'(n);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p,
                                              input logic [CAP_W-1:0] c);
    return (p == '0) ? PTR_W'(c - CAP_W'(1)) : (p - PTR_W'(1));
  endfunction

  // The output register loads whenever it is empty or being drained, so the
  // pending stage only waits while the output is stalled.
  assign out_load  = pend_valid && (!out_valid || !out_stall);
  assign in_stall  = pend_valid && !out_load;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = !pend_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign wp_inc    = ptr_inc(wp, cap);
  assign rp_inc    = ptr_inc(rp, cap);
  assign rp_dec    = ptr_dec(rp, cap);
  assign cur_empty = (wp == rp) && !full;

  // A written capacity of zero acts as one; values beyond the ring saturate.
  always_comb begin
    if (capacity == '0) begin
      cap_sat = CAP_W'(1);
    end else if (int'(capacity) > DEPTH) begin
      cap_sat = CAP_W'(DEPTH);
    end else begin
      cap_sat = CAP_W'(capacity);
    end
  end

  // Next pointer and flag state for the operation presented at the input.
  always_comb begin
    wp_next   = wp;
    rp_next   = rp;
    full_next = full;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = wp;
    pend_next = '0;

    case (op_t'(op))
      OP_TAIL_WR: begin
        if (!full) begin
          ram_we             = 1'b1;
          wp_next            = wp_inc;
          full_next          = (wp_inc == rp);
          pend_next.accepted = 1'b1;
        end
      end
      OP_TAIL_OVR: begin
        // When full, the oldest entry is dropped and the ring stays full.
        ram_we             = 1'b1;
        wp_next            = wp_inc;
        rp_next            = full ? rp_inc : rp;
        full_next          = full || (wp_inc == rp);
        pend_next.accepted = 1'b1;
      end
      OP_HEAD_INS: begin
        if (!full) begin
          ram_we             = 1'b1;
          ram_waddr          = rp_dec;
          rp_next            = rp_dec;
          full_next          = (rp_dec == wp);
          pend_next.accepted = 1'b1;
        end
      end
      OP_HEAD_RD: begin
        if (!cur_empty) begin
          ram_re             = in_acc;
          rp_next            = rp_inc;
          full_next          = 1'b0;
          pend_next.accepted = 1'b1;
          pend_next.is_read  = 1'b1;
        end
      end
      OP_CLEAR: begin
        wp_next   = '0;
        rp_next   = '0;
        full_next = 1'b0;
      end
      default: begin
      end
    endcase

    ram_we = ram_we && in_acc;

    nxt_empty = (wp_next == rp_next) && !full_next;

    if (full_next) begin
      fill_v = cap;
    end else if (wp_next >= rp_next) begin
      fill_v = CAP_W'(wp_next) - CAP_W'(rp_next);
    end else begin
      fill_v = CAP_W'(wp_next) + cap - CAP_W'(rp_next);
    end

    if (nxt_empty) begin
      free_v = cap;
    end else if (rp_next >= wp_next) begin
      free_v = CAP_W'(rp_next) - CAP_W'(wp_next);
    end else begin
      free_v = CAP_W'(rp_next) + cap - CAP_W'(wp_next);
    end

    pend_next.fill  = CNT_W'(fill_v);
    pend_next.free  = CNT_W'(free_v);
    pend_next.empty = nxt_empty;
    pend_next.full  = full_next;
  end

  rdwo_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (WIDTH'(wr_data)),
    .rd_en   (ram_re),
    .rd_addr (rp),
    .rd_data (ram_q)
  );

  // Ring state and capacity register. A capacity write empties the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      full <= 1'b0;
      cap  <= CAP_W'(DEPTH);
    end else if (cfg_acc) begin
      wp   <= '0;
      rp   <= '0;
      full <= 1'b0;
      cap  <= cap_sat;
    end else if (in_acc) begin
      wp   <= wp_next;
      rp   <= rp_next;
      full <= full_next;
    end
  end

  // Pending stage: holds the status while the memory read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_acc) begin
      pend_valid <= 1'b1;
    end else if (out_load) begin
      pend_valid <= 1'b0;
    end
    if (in_acc) begin
      pend <= pend_next;
    end
  end

  // Output register. The read data is held by the memory until the next
  // head read, which cannot be issued before this load.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      accepted   <= pend.accepted;
      rd_data    <= pend.is_read ? DATA_W'(ram_q) : '0;
      fill_count <= pend.fill;
      free_count <= pend.free;
      is_empty   <= pend.empty;
      is_full    <= pend.full;
    end
  end

endmodule

// ----- hdl/rdwo_checker.sv -----
module rdwo_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [rdwo_pkg::OP_W-1:0]   op,
  input logic [rdwo_pkg::DATA_W-1:0] wr_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        accepted,
  input logic [rdwo_pkg::DATA_W-1:0] rd_data,
  input logic [rdwo_pkg::CNT_W-1:0]  fill_count,
  input logic [rdwo_pkg::CNT_W-1:0]  free_count,
  input logic                        is_empty,
  input logic                        is_full,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [rdwo_pkg::CNT_W-1:0]  capacity
);

  import rdwo_pkg::*;

  // A full ring has no free slot.
  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_full |-> free_count == '0 && !is_empty)
    else $error("full result reports free slots or empty");

  // An empty ring holds nothing.
  a_empty_no_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> fill_count == '0)
    else $error("empty result reports a nonzero fill count");

  // Read data only comes with an accepted transaction.
  a_data_needs_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && rd_data != '0 |-> accepted)
    else $error("read data on a transaction that was not accepted");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rd_data) && $stable(fill_count))
    else $error("stalled result changed");

endmodule

bind ring_deque_with_overwrite_top rdwo_checker u_rdwo_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Self-checking testbench for the ring deque with overwrite.
//
// Every operation transaction that the block accepts is run through a behavioral
// ring model kept inside this module. The model produces the one result that the
// operation must return, and that result is queued. A checker takes each result
// transaction that leaves the block and compares it, field by field, with the
// oldest queued result.
//
// The run is split into named tests, called in turn from the main initial block:
//   - reset state and basic head/tail traffic on the full 16-entry ring,
//   - full and empty corners on a two-entry ring,
//   - capacity writes that are clamped (zero acts as one, large values saturate),
//   - long random traffic over many capacities,
//   - bursts after which the sender waits until every result is back.
// Both channels idle at random: the sender waits a random number of cycles before
// each operation, and the receiver stalls a random number of cycles before each
// result. Some stretches run with no idling at all so the pipeline stays full.
module tb;
  import rdwo_pkg::*;

  // The op field is three bits wide; the two codes past status are treated as
  // status by the block and are sent on purpose.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_PHASES    = 14;
  localparam int RANDOM_PER_PHASE = 130;
  localparam int MAX_PRINTED      = 100;

  // Fields of one result transaction.
  typedef struct packed {
    logic              acc;
    logic [DATA_W-1:0] rd_word;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  vacant;
    logic              empty;
    logic              full;
  } ring_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   op = '0;
  logic [DATA_W-1:0] wr_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              accepted;
  logic [DATA_W-1:0] rd_data;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  free_count;
  logic              is_empty;
  logic              is_full;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  capacity = '0;

  ring_deque_with_overwrite_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .wr_data    (wr_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted),
    .rd_data    (rd_data),
    .fill_count (fill_count),
    .free_count (free_count),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // A hard ceiling on the run. The slowest legal run is well under a fifth of this.
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Ring model. Pointers run modulo the capacity in use; the full flag tells a
  // full ring from an empty one when the two pointers meet.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int                wr_ptr;
  int                rd_ptr;
  bit                ring_full;
  int                ring_cap;

  ring_result_t pending_results [$];
  int           mismatch_count;
  int           result_index;

  // When set, the sender or the receiver runs without any idle cycles.
  bit sender_quiet;
  bit receiver_quiet;

  function automatic bit ring_is_empty();
    return (wr_ptr == rd_ptr) && !ring_full;
  endfunction

  function automatic int ring_occupancy();
    if (ring_full) return ring_cap;
    return (wr_ptr + ring_cap - rd_ptr) % ring_cap;
  endfunction

  function automatic int ring_vacancy();
    if (ring_is_empty()) return ring_cap;
    return (rd_ptr + ring_cap - wr_ptr) % ring_cap;
  endfunction

  function automatic void ring_empty_out();
    wr_ptr    = 0;
    rd_ptr    = 0;
    ring_full = 1'b0;
  endfunction

  function automatic void ring_push_tail(logic [DATA_W-1:0] data);
    ring_mem[wr_ptr] = data;
    wr_ptr = (wr_ptr + 1) % ring_cap;
    if (wr_ptr == rd_ptr) ring_full = 1'b1;
  endfunction

  // Applies one operation to the ring model and returns the result it must give.
  function automatic ring_result_t apply_ring_op(logic [OP_W-1:0] code,
                                                 logic [DATA_W-1:0] data);
    ring_result_t r;
    r = '0;
    case (code)
      OP_TAIL_WR: begin
        if (!ring_full) begin
          ring_push_tail(data);
          r.acc = 1'b1;
        end
      end
      OP_TAIL_OVR: begin
        // On a full ring the oldest entry is dropped to make room.
        if (ring_full) rd_ptr = (rd_ptr + 1) % ring_cap;
        ring_push_tail(data);
        r.acc = 1'b1;
      end
      OP_HEAD_INS: begin
        if (!ring_full) begin
          rd_ptr = (rd_ptr + ring_cap - 1) % ring_cap;
          ring_mem[rd_ptr] = data;
          if (rd_ptr == wr_ptr) ring_full = 1'b1;
          r.acc = 1'b1;
        end
      end
      OP_HEAD_RD: begin
        if (!ring_is_empty()) begin
          r.rd_word = ring_mem[rd_ptr];
          rd_ptr    = (rd_ptr + 1) % ring_cap;
          ring_full = 1'b0;
          r.acc     = 1'b1;
        end
      end
      OP_CLEAR: ring_empty_out();
      default: ;
    endcase
    r.fill   = CNT_W'(ring_occupancy());
    r.vacant = CNT_W'(ring_vacancy());
    r.empty  = ring_is_empty();
    r.full   = ring_full;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] seen);
    if (mismatch_count < MAX_PRINTED)
      $display("tb: result %0d: %s expected %0h, got %0h", result_index, what, want,
               seen);
    mismatch_count++;
  endtask

  task automatic check_result();
    ring_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none outstanding", '0, '0);
    end else begin
      want = pending_results.pop_front();
      if (accepted !== want.acc)      report_mismatch("accepted", want.acc, accepted);
      if (rd_data !== want.rd_word)   report_mismatch("rd_data", want.rd_word, rd_data);
      if (fill_count !== want.fill)   report_mismatch("fill_count", want.fill, fill_count);
      if (free_count !== want.vacant) report_mismatch("free_count", want.vacant, free_count);
      if (is_empty !== want.empty)    report_mismatch("is_empty", want.empty, is_empty);
      if (is_full !== want.full)      report_mismatch("is_full", want.full, is_full);
    end
    result_index++;
  endtask

  // Outputs are sampled at the rising edge, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) check_result();
  end

  // Receiver pacing: before each result transaction, stall for a random count.
  initial begin : result_pacing
    int hold;
    @(posedge clk);
    forever begin
      if (receiver_quiet) hold = 0;
      else if ($urandom_range(0, 1)) hold = $urandom_range(0, 2);
      else hold = $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !rst));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered and left right after a rising edge.
  // ---------------------------------------------------------------------------

  // Sends one operation transaction after a random idle gap, then predicts it.
  // With no gap the valid simply stays high into the next operation.
  task automatic send_op(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] data);
    int gap;
    if (sender_quiet) gap = 0;
    else if ($urandom_range(0, 1)) gap = $urandom_range(0, 2);
    else gap = $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    wr_data  <= data;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(apply_ring_op(code, data));
  endtask

  // Holds the sender off until every outstanding result has come back, then lets
  // the two-stage pipeline settle.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The capacity register is only written with the block idle. Writing it empties
  // the ring; zero is taken as one and anything above DEPTH as DEPTH.
  task automatic write_capacity(input logic [CNT_W-1:0] value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    capacity  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (value == 0) ring_cap = 1;
    else if (int'(value) > DEPTH) ring_cap = DEPTH;
    else ring_cap = int'(value);
    ring_empty_out();
  endtask

  // Operation mix. The fill-leaning mix drives the ring full, where overwrite and
  // dropped writes happen; the drain-leaning mix empties it, where reads fail.
  function automatic logic [OP_W-1:0] pick_op(bit drain_bias);
    int w;
    w = $urandom_range(0, 99);
    if (!drain_bias) begin
      if (w < 35) return OP_TAIL_WR;
      if (w < 55) return OP_TAIL_OVR;
      if (w < 75) return OP_HEAD_INS;
      if (w < 93) return OP_HEAD_RD;
      if (w < 95) return OP_CLEAR;
    end else begin
      if (w < 15) return OP_TAIL_WR;
      if (w < 25) return OP_TAIL_OVR;
      if (w < 35) return OP_HEAD_INS;
      if (w < 85) return OP_HEAD_RD;
      if (w < 88) return OP_CLEAR;
    end
    if (w < 97) return OP_STATUS;
    return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] capacity_for_phase(int phase);
    case (phase)
      0:       return 5'd1;
      1:       return 5'd2;
      2:       return 5'd3;
      3:       return 5'd16;
      4:       return 5'd4;
      5:       return 5'd5;
      6:       return 5'd31;
      7:       return 5'd8;
      8:       return 5'd15;
      9:       return 5'd0;
      10:      return 5'd17;
      default: return CNT_W'($urandom_range(0, 31));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset leaves a 16-entry empty ring. Checks status, a read of the empty ring,
  // the spare op codes, data extremes through both ends, and clear.
  task automatic test_reset_state();
    send_op(OP_STATUS, '0);
    send_op(OP_HEAD_RD, '0);
    send_op(OP_SPARE_6, 32'h0000_0000);
    send_op(OP_SPARE_7, 32'hFFFF_FFFF);
    send_op(OP_TAIL_WR, 32'h0000_0000);
    send_op(OP_TAIL_WR, 32'hFFFF_FFFF);
    send_op(OP_HEAD_INS, 32'hA5A5_A5A5);
    send_op(OP_HEAD_RD, '0);
    send_op(OP_HEAD_RD, '0);
    send_op(OP_HEAD_RD, '0);
    send_op(OP_CLEAR, 32'h5A5A_5A5A);
  endtask

  // A two-entry ring reaches full quickly: a plain tail write and a head insert
  // are dropped there, while an overwriting tail write pushes out the oldest.
  task automatic test_small_ring_edges();
    write_capacity(5'd2);
    send_op(OP_TAIL_WR, 32'h0000_0001);
    send_op(OP_TAIL_WR, 32'h0000_0002);
    send_op(OP_TAIL_WR, 32'h0000_0003);
    send_op(OP_HEAD_INS, 32'h0000_0004);
    send_op(OP_TAIL_OVR, 32'h0000_0005);
    send_op(OP_HEAD_RD, '0);
    send_op(OP_HEAD_INS, 32'h0000_0006);
    send_op(OP_HEAD_RD, '0);
    send_op(OP_HEAD_RD, '0);
    send_op(OP_TAIL_OVR, 32'h0000_0007);
    send_op(OP_CLEAR, '0);
  endtask

  // Zero behaves as a one-entry ring, where an overwrite wraps onto itself; an
  // all-ones write saturates to the full depth.
  task automatic test_capacity_clamping();
    write_capacity(5'd0);
    send_op(OP_TAIL_OVR, 32'h1234_5678);
    send_op(OP_TAIL_OVR, 32'h8765_4321);
    send_op(OP_HEAD_RD, '0);
    write_capacity(5'd31);
    send_op(OP_STATUS, '0);
  endtask

  // Random traffic over a spread of capacities, choosing at random between a fill-leaning
  // and a drain-leaning mix, with stretches where one or both sides never idle.
  task automatic test_random_traffic();
    bit drain_bias;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_capacity(capacity_for_phase(phase));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          drain_bias     = $urandom_range(0, 1);
          sender_quiet   = ($urandom_range(0, 3) == 0);
          receiver_quiet = ($urandom_range(0, 3) == 0);
        end
        send_op(pick_op(drain_bias), pick_data());
      end
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // Back-to-back bursts, each followed by the sender waiting until every result
  // is back, so the pipeline goes from full pressure to fully idle.
  task automatic test_drain_pause();
    write_capacity(5'd6);
    for (int b = 0; b < 3; b++) begin
      sender_quiet = 1'b1;
      for (int n = 0; n < 20; n++) send_op(pick_op(b == 2), pick_data());
      sender_quiet = 1'b0;
      wait_results_drained();
    end
  endtask

  initial begin
    ring_cap = DEPTH;
    ring_empty_out();
    for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
    mismatch_count = 0;
    result_index   = 0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_small_ring_edges();
    test_capacity_clamping();
    test_random_traffic();
    test_drain_pause();

    // Let the last results drain, then give any stray transaction time to show.
    wait_results_drained();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
